FILE: design/lookahead_peak_limiter_top_assert.svh
// Assertion macros used by the checker file.
`ifndef LOOKAHEAD_PEAK_LIMITER_TOP_ASSERT_SVH
`define LOOKAHEAD_PEAK_LIMITER_TOP_ASSERT_SVH

// same-cycle implication
`define LPL_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lpl_pkg.sv
package lpl_pkg;

  localparam int DEF_DELAY    = 10;
  localparam int DEF_CHANNELS = 8;

  localparam int SAMPLE_W   = 16;
  localparam int CHAN_W     = 3;
  localparam int THR_W      = 16;
  localparam int COEF_W     = 17;
  localparam int FRAC_W     = 16;
  localparam int ALU_W      = 18;
  localparam int ACC_W      = 36;
  localparam int APB_W      = 32;
  localparam int REG_ADDR_W = 4;
  localparam int DIV_STEPS  = 16;
  localparam int DIV_CNT_W  = 4;

  localparam logic [COEF_W-1:0] UNITY         = 17'h10000;
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 16'd32768;
  localparam logic [COEF_W-1:0] ATTACK_RST    = 17'd19661;
  localparam logic [COEF_W-1:0] RELEASE_RST   = 17'd655;

  typedef enum logic [1:0] {
    REG_THRESHOLD,
    REG_ATTACK,
    REG_RELEASE
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PK_HELD,
    ST_PK_NEW,
    ST_PK_STORE,
    ST_DIV_CHECK,
    ST_DIV,
    ST_DIV_STORE,
    ST_GN_HELD,
    ST_GN_NEW,
    ST_GN_STORE,
    ST_OUT_MUL,
    ST_OUT_LOAD
  } state_t;

  typedef enum logic [2:0] {
    ALU_HOLD,
    ALU_MUL,
    ALU_MAC,
    ALU_DIV_LOAD,
    ALU_DIV_STEP
  } alu_op_t;

  typedef enum logic [2:0] {
    OPND_PK_HELD,
    OPND_PK_NEW,
    OPND_GN_HELD,
    OPND_GN_NEW,
    OPND_OUT
  } opnd_sel_t;

  typedef struct packed {
    alu_op_t   alu_op;
    opnd_sel_t opnd_sel;
    logic      peak_load;
    logic      target_load;
    logic      target_unity;
    logic      gain_load;
    logic      line_update;
    logic      out_load;
    logic      busy;
  } ctrl_t;

  function automatic logic [COEF_W-1:0] sat_coef(input logic [COEF_W-1:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

  function automatic logic signed [ALU_W-1:0] to_opnd(input logic [COEF_W-1:0] v);
    return $signed({1'b0, v});
  endfunction

endpackage

FILE: design/lpl_ram.sv
module lpl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 80
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/lpl_alu.sv
module lpl_alu (
  input  logic                                clk,
  input  lpl_pkg::alu_op_t                    op,
  input  logic signed [lpl_pkg::ALU_W-1:0]    opnd_a,
  input  logic signed [lpl_pkg::ALU_W-1:0]    opnd_b,
  input  logic [lpl_pkg::THR_W-1:0]           dividend,
  input  logic [lpl_pkg::THR_W-1:0]           divisor,
  output logic [lpl_pkg::ACC_W-1:0]           acc
);
  import lpl_pkg::*;

  logic signed [ACC_W-1:0] prod;
  logic [ACC_W-1:0]        acc_next;
  logic [32:0]             shifted;
  logic [17:0]             trial;

  assign prod    = opnd_a * opnd_b;
  assign shifted = {acc[31:0], 1'b0};
  assign trial   = {1'b0, shifted[32:16]} - {2'b0, divisor};

  always_comb begin
    case (op)
      ALU_MUL:      acc_next = prod;
      ALU_MAC:      acc_next = acc + prod;
      ALU_DIV_LOAD: acc_next = ACC_W'({dividend, {FRAC_W{1'b0}}});
      ALU_DIV_STEP: begin
        if (!trial[17]) begin
          acc_next = ACC_W'({trial[16:0], shifted[15:1], 1'b1});
        end else begin
          acc_next = ACC_W'(shifted);
        end
      end
      default:      acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

endmodule

FILE: design/lpl_seq.sv
module lpl_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           peak_over,
  input  logic           out_full,
  output lpl_pkg::ctrl_t ctrl
);
  import lpl_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_last;

  assign div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_fire) state_next = ST_PK_HELD;
      ST_PK_HELD:   state_next = ST_PK_NEW;
      ST_PK_NEW:    state_next = ST_PK_STORE;
      ST_PK_STORE:  state_next = ST_DIV_CHECK;
      ST_DIV_CHECK: state_next = peak_over ? ST_DIV : ST_GN_HELD;
      ST_DIV:       if (div_last) state_next = ST_DIV_STORE;
      ST_DIV_STORE: state_next = ST_GN_HELD;
      ST_GN_HELD:   state_next = ST_GN_NEW;
      ST_GN_NEW:    state_next = ST_GN_STORE;
      ST_GN_STORE:  state_next = ST_OUT_MUL;
      ST_OUT_MUL:   state_next = ST_OUT_LOAD;
      ST_OUT_LOAD:  if (!out_full) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.alu_op   = ALU_HOLD;
    ctrl.opnd_sel = OPND_PK_HELD;
    ctrl.busy     = (state != ST_IDLE);
    case (state)
      ST_PK_HELD: begin
        ctrl.alu_op   = ALU_MUL;
        ctrl.opnd_sel = OPND_PK_HELD;
      end
      ST_PK_NEW: begin
        ctrl.alu_op   = ALU_MAC;
        ctrl.opnd_sel = OPND_PK_NEW;
      end
      ST_PK_STORE: ctrl.peak_load = 1'b1;
      ST_DIV_CHECK: begin
        if (peak_over) begin
          ctrl.alu_op = ALU_DIV_LOAD;
        end else begin
          ctrl.target_unity = 1'b1;
        end
      end
      ST_DIV:       ctrl.alu_op = ALU_DIV_STEP;
      ST_DIV_STORE: ctrl.target_load = 1'b1;
      ST_GN_HELD: begin
        ctrl.alu_op   = ALU_MUL;
        ctrl.opnd_sel = OPND_GN_HELD;
      end
      ST_GN_NEW: begin
        ctrl.alu_op   = ALU_MAC;
        ctrl.opnd_sel = OPND_GN_NEW;
      end
      ST_GN_STORE: ctrl.gain_load = 1'b1;
      ST_OUT_MUL: begin
        ctrl.alu_op      = ALU_MUL;
        ctrl.opnd_sel    = OPND_OUT;
        ctrl.line_update = 1'b1;
      end
      ST_OUT_LOAD: ctrl.out_load = !out_full;
      default: ;
    endcase
  end

endmodule

FILE: design/lookahead_peak_limiter_top.sv
// Look-ahead peak limiter. Each item is one signed Q1.15 sample and a channel
// number; the result is the sample that entered the same channel DELAY items
// earlier, scaled by a smoothed gain that a shared peak follower drives toward
// threshold/peak, or toward unity while the peak is not above the threshold.
// All arithmetic runs through one multiply-accumulate and divide-step unit
// under a small sequencer, so in_stall is high while an item is at work: from
// acceptance until its result is loaded, including, when the peak is above
// the threshold, a restoring divide of one quotient bit per cycle, and any wait
// for the previous result to be taken. The delay lines live in one
// CHANNELS*DELAY entry RAM; a per-channel fill flag makes unfilled entries read
// as zero, so there is no clearing pass after reset. Channel numbers at or
// above CHANNELS give a zero result and leave the delay lines untouched.
// Registers over APB: threshold at 0x0, attack_coeff at 0x4, release_coeff at
// 0x8; a coefficient keeps its write's low 17 bits, and values above 65536 saturate to 65536.
module lookahead_peak_limiter_top #(
  parameter int DELAY    = lpl_pkg::DEF_DELAY,
  parameter int CHANNELS = lpl_pkg::DEF_CHANNELS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [lpl_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic [lpl_pkg::CHAN_W-1:0]           channel,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lpl_pkg::SAMPLE_W-1:0]  sample_out,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lpl_pkg::REG_ADDR_W-1:0]       paddr,
  input  logic [lpl_pkg::APB_W-1:0]            pwdata,
  output logic [lpl_pkg::APB_W-1:0]            prdata,
  output logic                                 pready
);
  import lpl_pkg::*;

  localparam int PTR_W  = (DELAY > 1) ? $clog2(DELAY) : 1;
  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = CHANNELS * DELAY;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ctrl_t ctrl;

  logic [THR_W-1:0]  threshold;
  logic [COEF_W-1:0] attack_coeff;
  logic [COEF_W-1:0] release_coeff;
  reg_idx_t          reg_idx;
  logic              cfg_write;

  logic              in_fire;
  logic              in_chan_ok;
  logic [IDX_W-1:0]  in_idx;
  logic [SAMPLE_W-1:0] in_mag;
  logic [ADDR_W-1:0] in_slot;

  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] mag_q;
  logic              chan_ok_q;
  logic [IDX_W-1:0]  idx_q;
  logic [ADDR_W-1:0] slot_q;

  logic [PTR_W-1:0]  ptr [CHANNELS];
  logic              filled [CHANNELS];

  logic [THR_W-1:0]  peak;
  logic [COEF_W-1:0] gain;
  logic [COEF_W-1:0] target;

  logic [COEF_W-1:0] pk_coef;
  logic [COEF_W-1:0] gn_coef;
  logic signed [ALU_W-1:0] opnd_a;
  logic signed [ALU_W-1:0] opnd_b;
  logic [ACC_W-1:0]  acc;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [SAMPLE_W-1:0] delayed;
  logic              out_full;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[REG_ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RST;
      attack_coeff  <= ATTACK_RST;
      release_coeff <= RELEASE_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_THRESHOLD: threshold     <= pwdata[THR_W-1:0];
        REG_ATTACK:    attack_coeff  <= sat_coef(pwdata[COEF_W-1:0]);
        REG_RELEASE:   release_coeff <= sat_coef(pwdata[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = APB_W'(threshold);
      REG_ATTACK:    prdata = APB_W'(attack_coeff);
      REG_RELEASE:   prdata = APB_W'(release_coeff);
      default:       prdata = '0;
    endcase
  end

  assign in_stall   = ctrl.busy;
  assign in_fire    = in_valid && !in_stall;
  assign out_full   = out_valid && out_stall;
  assign in_chan_ok = (int'(channel) < CHANNELS);
  assign in_idx     = IDX_W'(channel);
  assign in_mag     = sample_in[SAMPLE_W-1] ? (~sample_in + 1'b1) : sample_in;
  assign in_slot    = ADDR_W'(in_idx) * ADDR_W'(DELAY) + ADDR_W'(ptr[in_idx]);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_q  <= sample_in;
      mag_q     <= in_mag;
      chan_ok_q <= in_chan_ok;
      idx_q     <= in_idx;
      slot_q    <= in_slot;
    end
  end

  lpl_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_lpl_ram (
    .clk  (clk),
    .we   (ctrl.line_update && chan_ok_q),
    .waddr(slot_q),
    .wdata(sample_q),
    .re   (in_fire && in_chan_ok),
    .raddr(in_slot),
    .rdata(ram_rdata)
  );

  assign delayed = (chan_ok_q && filled[idx_q]) ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ptr[i]    <= '0;
        filled[i] <= 1'b0;
      end
    end else if (ctrl.line_update && chan_ok_q) begin
      if (ptr[idx_q] == PTR_W'(DELAY - 1)) begin
        ptr[idx_q]    <= '0;
        filled[idx_q] <= 1'b1;
      end else begin
        ptr[idx_q] <= ptr[idx_q] + 1'b1;
      end
    end
  end

  assign pk_coef = (mag_q > peak) ? attack_coeff : release_coeff;
  assign gn_coef = (gain > target) ? attack_coeff : release_coeff;

  always_comb begin
    case (ctrl.opnd_sel)
      OPND_PK_HELD: begin
        opnd_a = to_opnd(UNITY - pk_coef);
        opnd_b = to_opnd(COEF_W'(peak));
      end
      OPND_PK_NEW: begin
        opnd_a = to_opnd(pk_coef);
        opnd_b = to_opnd(COEF_W'(mag_q));
      end
      OPND_GN_HELD: begin
        opnd_a = to_opnd(UNITY - gn_coef);
        opnd_b = to_opnd(gain);
      end
      OPND_GN_NEW: begin
        opnd_a = to_opnd(gn_coef);
        opnd_b = to_opnd(target);
      end
      OPND_OUT: begin
        opnd_a = to_opnd(gain);
        opnd_b = $signed({{(ALU_W - SAMPLE_W){delayed[SAMPLE_W-1]}}, delayed});
      end
      default: begin
        opnd_a = '0;
        opnd_b = '0;
      end
    endcase
  end

  lpl_alu u_lpl_alu (
    .clk     (clk),
    .op      (ctrl.alu_op),
    .opnd_a  (opnd_a),
    .opnd_b  (opnd_b),
    .dividend(threshold),
    .divisor (peak),
    .acc     (acc)
  );

  lpl_seq u_lpl_seq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .peak_over(peak > threshold),
    .out_full (out_full),
    .ctrl     (ctrl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= '0;
      gain <= UNITY;
    end else begin
      if (ctrl.peak_load) begin
        peak <= acc[31:16];
      end
      if (ctrl.gain_load) begin
        gain <= acc[32:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.target_unity) begin
      target <= UNITY;
    end else if (ctrl.target_load) begin
      target <= {1'b0, acc[15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      sample_out <= acc[31:16];
    end
  end

endmodule

FILE: design/lpl_checker.sv
module lpl_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [lpl_pkg::SAMPLE_W-1:0] sample_out
);

`include "lookahead_peak_limiter_top_assert.svh"

  `LPL_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "item accepted but block not busy")
  `LPL_ASSERT_IMP(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall), "result appeared while idle")
  `LPL_ASSERT_IMP(a_done_has_result, clk, rst, $fell(in_stall), out_valid, "work ended without a result")
  `LPL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(sample_out), "stalled result changed")

endmodule

bind lookahead_peak_limiter_top lpl_checker u_lpl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .sample_out(sample_out)
);

FILE: verif/lookahead_peak_limiter_top_test.sv
`timescale 1ns / 100ps

module lookahead_peak_limiter_top_test;
  import lpl_pkg::*;

  localparam int DELAY     = DEF_DELAY;
  localparam int CHANNELS  = DEF_CHANNELS;
  localparam int REG_COUNT = 3;
  localparam int SETTLE    = 40;

  typedef enum int {
    LEVEL_ANY,
    LEVEL_EXTREME,
    LEVEL_QUIET,
    LEVEL_LOUD,
    LEVEL_SILENT
  } level_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] s;
    logic [CHAN_W-1:0]          ch;
    logic                       known;
    logic signed [SAMPLE_W-1:0] val;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic [CHAN_W-1:0]          channel = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [REG_ADDR_W-1:0]      paddr = '0;
  logic [APB_W-1:0]           pwdata = '0;
  logic [APB_W-1:0]           prdata;
  logic                       pready;

  logic [THR_W-1:0]           lim_threshold = THRESHOLD_RST;
  logic [COEF_W-1:0]          lim_attack = ATTACK_RST;
  logic [COEF_W-1:0]          lim_release = RELEASE_RST;
  logic [COEF_W-1:0]          env_peak = '0;
  logic [COEF_W-1:0]          env_gain = UNITY;
  logic signed [SAMPLE_W-1:0] delay_line [CHANNELS*DELAY];
  int                         delay_pos [CHANNELS];

  logic signed [SAMPLE_W-1:0] pending_out [$];
  int                         mismatches = 0;
  int                         burst_left = 1;
  int                         stall_run = 0;
  logic                       stall_now = 1'b0;
  dir_row_t                   dir_rows [24];

  lookahead_peak_limiter_top #(
    .DELAY(DELAY),
    .CHANNELS(CHANNELS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_in(sample_in),
    .channel(channel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 40) begin
      $display("%0t mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic logic [COEF_W-1:0] one_pole(input longint unsigned held,
                                                  input longint unsigned toward,
                                                  input longint unsigned c);
    return COEF_W'(((65536 - c) * held + c * toward) >> 16);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] limit_sample(
      input logic signed [SAMPLE_W-1:0] s, input logic [CHAN_W-1:0] ch);
    longint sv;
    longint unsigned mag;
    longint unsigned target;
    longint delayed;
    longint prod;
    logic [COEF_W-1:0] coef;
    int slot;
    sv = longint'(s);
    mag = (sv < 0) ? -sv : sv;
    coef = (mag > env_peak) ? lim_attack : lim_release;
    env_peak = one_pole(64'(env_peak), mag, 64'(coef));
    if (env_peak > lim_threshold) begin
      target = (longint'(lim_threshold) << 16) / env_peak;
    end else begin
      target = 64'(UNITY);
    end
    coef = (env_gain > target) ? lim_attack : lim_release;
    env_gain = one_pole(64'(env_gain), target, 64'(coef));
    delayed = 0;
    if (int'(ch) < CHANNELS) begin
      slot = int'(ch) * DELAY + delay_pos[ch];
      delayed = longint'(delay_line[slot]);
      delay_line[slot] = s;
      delay_pos[ch] = (delay_pos[ch] + 1 >= DELAY) ? 0 : delay_pos[ch] + 1;
    end
    prod = longint'(env_gain) * delayed;
    return SAMPLE_W'(prod >>> 16);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] make_sample(input level_t level);
    int mag;
    case (level)
      LEVEL_EXTREME: begin
        case ($urandom_range(0, 5))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh8001;
          3: return 16'sh0000;
          4: return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
      LEVEL_QUIET: return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      LEVEL_LOUD: begin
        mag = $urandom_range(24000, 32768);
        if ($urandom_range(0, 1) == 0) begin
          return SAMPLE_W'(-mag);
        end
        return (mag > 32767) ? 16'sh7FFF : SAMPLE_W'(mag);
      end
      LEVEL_SILENT: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input int idx, input logic [APB_W-1:0] value);
    logic [APB_W-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ADDR_W'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_THRESHOLD: lim_threshold = value[THR_W-1:0];
      REG_ATTACK:    lim_attack = (value[COEF_W-1:0] > UNITY) ? UNITY : value[COEF_W-1:0];
      REG_RELEASE:   lim_release = (value[COEF_W-1:0] > UNITY) ? UNITY : value[COEF_W-1:0];
      default:       ;
    endcase
    if (idx < REG_COUNT) begin
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      case (idx)
        REG_THRESHOLD: want = APB_W'(lim_threshold);
        REG_ATTACK:    want = APB_W'(lim_attack);
        default:       want = APB_W'(lim_release);
      endcase
      if (prdata !== want) begin
        report_mismatch($sformatf("register %0d reads %0h, expected %0h", idx, prdata, want));
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic signed [SAMPLE_W-1:0] s, input logic [CHAN_W-1:0] ch,
                           input logic known, input logic signed [SAMPLE_W-1:0] fixed_val);
    logic signed [SAMPLE_W-1:0] want;
    int gap;
    in_valid <= 1'b1;
    sample_in <= s;
    channel <= ch;
    do @(posedge clk); while (in_stall);
    want = limit_sample(s, ch);
    if (known) begin
      want = fixed_val;
    end
    pending_out = {pending_out, want};
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
    end
  endtask

  task automatic drain(input int extra);
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    level_t level;
    int level_left;
    int chan_left;
    logic [CHAN_W-1:0] ch;
    level = LEVEL_ANY;
    level_left = 0;
    chan_left = 0;
    ch = '0;
    for (int n = 0; n < count; n++) begin
      if (level_left == 0) begin
        level = level_t'($urandom_range(0, 4));
        level_left = $urandom_range(1, 30);
      end
      if (chan_left == 0) begin
        ch = CHAN_W'($urandom_range(0, 7));
        chan_left = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 25) : 1;
      end
      level_left--;
      chan_left--;
      send_item(make_sample(level), ch, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input logic [APB_W-1:0] thr, input logic [APB_W-1:0] atk,
                           input logic [APB_W-1:0] rel, input int count, input bit hold_midway);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_ATTACK, atk);
    write_reg(REG_RELEASE, rel);
    run_random(count / 2);
    if (hold_midway) begin
      drain(0);
    end
    run_random(count - count / 2);
    drain(SETTLE);
  endtask

  always @(posedge clk) begin
    stall_run = stall_run - 1;
    if (stall_run <= 0) begin
      stall_now = !stall_now;
      if (stall_now) begin
        stall_run = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 4);
      end else begin
        stall_run = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 120 : 6);
      end
    end
    out_stall <= stall_now;
  end

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        report_mismatch($sformatf("unexpected sample_out %0d", sample_out));
      end else begin
        want = pending_out.pop_front();
        if (sample_out !== want) begin
          report_mismatch($sformatf("sample_out %0d, expected %0d", sample_out, want));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    foreach (delay_line[i]) delay_line[i] = '0;
    foreach (delay_pos[i]) delay_pos[i] = 0;
    dir_rows = '{
      '{16'sh7FFF, 3'd0, 1'b1, 16'sh0000},
      '{16'sh8000, 3'd0, 1'b1, 16'sh0000},
      '{16'sh0000, 3'd0, 1'b1, 16'sh0000},
      '{16'shFFFF, 3'd0, 1'b1, 16'sh0000},
      '{16'sh0001, 3'd0, 1'b1, 16'sh0000},
      '{16'sh4000, 3'd1, 1'b1, 16'sh0000},
      '{16'shC000, 3'd7, 1'b1, 16'sh0000},
      '{16'sh1234, 3'd0, 1'b1, 16'sh0000},
      '{16'shEDCC, 3'd0, 1'b1, 16'sh0000},
      '{16'sh7FFF, 3'd0, 1'b1, 16'sh0000},
      '{16'sh8000, 3'd0, 1'b1, 16'sh0000},
      '{16'sh5555, 3'd0, 1'b1, 16'sh0000},
      '{16'shAAAA, 3'd0, 1'b1, 16'sh7FFF},
      '{16'sh0000, 3'd0, 1'b1, 16'sh8000},
      '{16'sh0100, 3'd0, 1'b0, 16'sh0000},
      '{16'sh7FFF, 3'd7, 1'b0, 16'sh0000},
      '{16'sh8000, 3'd2, 1'b1, 16'sh0000},
      '{16'sh7FFF, 3'd3, 1'b1, 16'sh0000},
      '{16'sh8000, 3'd4, 1'b1, 16'sh0000},
      '{16'sh0001, 3'd5, 1'b1, 16'sh0000},
      '{16'shFFFE, 3'd6, 1'b1, 16'sh0000},
      '{16'sh8001, 3'd1, 1'b1, 16'sh0000},
      '{16'sh3FFF, 3'd2, 1'b0, 16'sh0000},
      '{16'shFFFF, 3'd0, 1'b0, 16'sh0000}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].s, dir_rows[i].ch, dir_rows[i].known, dir_rows[i].val);
    end
    run_random(80);
    drain(SETTLE);
    run_phase(32'h0000_4000, 32'h0001_FFFF, 32'h0000_0000, 100, 1'b0);
    run_phase(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 100, 1'b0);
    write_reg(REG_COUNT, $urandom);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_8000, 100, 1'b1);
    run_phase(32'hABCD_2000, 32'h5432_4CCD, 32'hFFFE_028F, 100, 1'b0);
    run_phase($urandom_range(1, 32768), $urandom_range(0, 65536), $urandom_range(0, 65536),
              100, 1'b0);
    run_phase($urandom_range(1, 32768), $urandom_range(0, 65536), $urandom_range(0, 4096),
              100, 1'b0);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/lpl_pkg.sv
design/lpl_ram.sv
design/lpl_alu.sv
design/lpl_seq.sv
design/lookahead_peak_limiter_top.sv
design/lpl_checker.sv
verif/lookahead_peak_limiter_top_test.sv
